>>> src/pitp_pkg.sv
// shared types, constants and helpers of the prefixed integer text parser
package pitp_pkg;

    localparam int unsigned DEF_MAX_UNIT_BYTES = 4;
    localparam int unsigned UNIT_CMP_W         = 4;
    localparam int unsigned ACC_W              = 31;
    localparam int unsigned APB_ADDR_W         = 3;
    localparam int unsigned QUEUE_DEPTH        = 2;

    localparam logic [0:0] REG_UNIT_BYTES      = 1'b0;
    localparam logic [0:0] REG_HIGH_BYTE_FIRST = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;

    localparam logic [4:0] NOT_DIGIT = 5'd16;

    typedef enum logic [4:0] {
        PH_LEAD   = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_POST   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef struct packed {
        logic       use_char;
        logic       last;
        logic       is_blank;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_x;
        logic       is_b;
        logic [4:0] digit;
    } char_item_t;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 5'(c - CH_ZERO);
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            d = 5'(c - CH_LO_A + 8'd10);
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            d = 5'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_value(input radix_t r);
        logic [4:0] v;
        case (r)
            RADIX_HEX: v = 5'd16;
            RADIX_OCT: v = 5'd8;
            RADIX_BIN: v = 5'd2;
            default:   v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

>>> src/prefixed_integer_text_parser_unit.sv
// top level of the prefixed integer text parser with its configuration registers
//
// channel   direction  transfer when          payload
// s_axis    in         tvalid & tready        tdata = byte_in, tlast = last_byte
// m_axis    out        tvalid & tready        tdata = number, tuser = overflowed
// apb       in         psel&penable&pwrite    unit_bytes at 0, high_byte_first at 4
//
// one byte per cycle while s_axis_tready is high; the front end classifies it on arrival
// unless stalled, the back end takes one queued character per cycle via one shift-add unit
// m_axis_tvalid is registered and rises once the back end pops the character marked tlast
// stalls on m_axis hold the back end; the two-entry queue then fills and drops s_axis_tready
// reset clears parse state and sets unit_bytes to 1, high_byte_first to 0
module prefixed_integer_text_parser_unit
    import pitp_pkg::*;
#(
    parameter int unsigned MAX_UNIT_BYTES = DEF_MAX_UNIT_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] byte_in
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // [31:0] number
    output logic                  m_axis_tuser,  // [0] overflowed
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [2:0] unit_bytes_val_reg;
    logic       hbf_reg;
    logic       cfg_wr;
    logic       in_fire;
    logic       push;
    char_item_t push_item;
    char_item_t head;
    logic       not_empty;
    logic       not_full;
    logic       pop;
    logic [1:0] q_count;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = not_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        case (paddr[2])
            REG_UNIT_BYTES: prdata = {29'd0, unit_bytes_val_reg};
            default:        prdata = {31'd0, hbf_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_bytes_val_reg <= 3'd1;
            hbf_reg            <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_UNIT_BYTES: unit_bytes_val_reg <= pwdata[2:0];
                default:        hbf_reg            <= pwdata[0];
            endcase
        end
    end

    pitp_front #(
        .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .unit_bytes      (unit_bytes_val_reg),
        .high_byte_first (hbf_reg),
        .in_fire         (in_fire),
        .byte_in         (s_axis_tdata),
        .last_byte       (s_axis_tlast),
        .push            (push),
        .item            (push_item)
    );

    pitp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full),
        .count     (q_count)
    );

    pitp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (not_empty),
        .item       (head),
        .item_pop   (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .number     (m_axis_tdata),
        .overflowed (m_axis_tuser)
    );

    // an overflowed result always carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("overflowed result with non-zero number");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 2'(QUEUE_DEPTH))
        else $error("character queue count out of range");

    // the unit size register follows a write to its address
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[2] == REG_UNIT_BYTES
        |=> unit_bytes_val_reg == $past(pwdata[2:0]))
        else $error("unit size register not updated by write");

    // the character marked last is never popped while a result is stalled on m_axis
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !pop || !head.last)
        else $error("result overwritten while stalled");

endmodule

>>> src/pitp_front.sv
// front end: code unit byte selection and character classification
module pitp_front
    import pitp_pkg::*;
#(
    parameter int unsigned MAX_UNIT_BYTES = DEF_MAX_UNIT_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [2:0]       unit_bytes,
    input  logic             high_byte_first,
    input  logic             in_fire,
    input  logic [7:0]       byte_in,
    input  logic             last_byte,
    output logic             push,
    output char_item_t       item
);

    localparam int unsigned PW = (MAX_UNIT_BYTES > 1) ? $clog2(MAX_UNIT_BYTES) : 1;

    logic [PW-1:0]         pos_reg;
    logic [PW-1:0]         pos_next;
    logic [UNIT_CMP_W-1:0] unit_raw;
    logic [UNIT_CMP_W-1:0] unit_eff;
    logic [UNIT_CMP_W-1:0] unit_m1;
    logic [UNIT_CMP_W-1:0] sel;
    logic [UNIT_CMP_W-1:0] pos_ext;

    always_comb
    begin
        unit_raw = UNIT_CMP_W'(unit_bytes);
        if (unit_raw == '0)
        begin
            unit_eff = UNIT_CMP_W'(1);
        end
        else if (unit_raw > UNIT_CMP_W'(MAX_UNIT_BYTES))
        begin
            unit_eff = UNIT_CMP_W'(MAX_UNIT_BYTES);
        end
        else
        begin
            unit_eff = unit_raw;
        end
        unit_m1 = unit_eff - UNIT_CMP_W'(1);
        sel     = high_byte_first ? unit_m1 : '0;
        pos_ext = UNIT_CMP_W'(pos_reg);
        if (last_byte || pos_ext >= unit_m1)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    always_comb
    begin
        item.use_char = (pos_ext == sel);
        item.last     = last_byte;
        item.is_blank = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
        item.is_minus = (byte_in == CH_MINUS);
        item.is_plus  = (byte_in == CH_PLUS);
        item.is_zero  = (byte_in == CH_ZERO);
        item.is_x     = (byte_in == CH_LO_X) || (byte_in == CH_UP_X);
        item.is_b     = (byte_in == CH_LO_B) || (byte_in == CH_UP_B);
        item.digit    = digit_of(byte_in);
        push          = in_fire && (item.use_char || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_fire)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> src/pitp_queue.sv
// two-entry queue of classified characters between front and back end
module pitp_queue
    import pitp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_item_t push_item,
    input  logic       pop,
    output char_item_t head,
    output logic       not_empty,
    output logic       not_full,
    output logic [1:0] count
);

    char_item_t mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'(QUEUE_DEPTH));
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> src/pitp_back.sv
// back end: parse state machine, digit accumulation and result register
module pitp_back
    import pitp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  char_item_t  item,
    output logic        item_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] number,
    output logic        overflowed
);

    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              neg_reg, neg_next;
    radix_t            radix_reg, radix_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg;
    logic [31:0]       number_reg;
    logic              ovf_out_reg;

    radix_t            radix_eff;
    logic [4:0]        base;
    logic [ACC_W+3:0]  prod;
    logic [ACC_W+4:0]  sum;
    logic              digit_ok;
    logic              sum_ovf;
    logic              back_ready;
    logic [31:0]       mag;

    assign back_ready = !out_valid_reg || out_ready;
    assign item_pop   = item_valid && back_ready;
    assign out_valid  = out_valid_reg;
    assign number     = number_reg;
    assign overflowed = ovf_out_reg;

    // after a bare zero the base becomes octal for the same character
    always_comb
    begin
        radix_eff = radix_reg;
        if (phase_reg == PH_ZERO && !item.is_x && !item.is_b)
        begin
            radix_eff = RADIX_OCT;
        end
        base = radix_value(radix_eff);
        case (radix_eff)
            RADIX_HEX: prod = {acc_reg, 4'b0};
            RADIX_OCT: prod = {1'b0, acc_reg, 3'b0};
            RADIX_BIN: prod = {3'b0, acc_reg, 1'b0};
            default:   prod = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0};
        endcase
        sum      = {1'b0, prod} + (ACC_W+5)'(item.digit);
        digit_ok = (item.digit < base);
        sum_ovf  = (sum[ACC_W+4:ACC_W] != '0);
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        ovf_next   = ovf_reg;
        if (item.use_char)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (item.is_minus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_POST;
                    end
                    else if (item.is_plus)
                    begin
                        phase_next = PH_POST;
                    end
                    else if (item.is_zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (!item.is_blank)
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
                PH_ZERO:
                begin
                    radix_next = radix_eff;
                    if (item.is_x)
                    begin
                        radix_next = RADIX_HEX;
                        phase_next = PH_POST;
                    end
                    else if (item.is_b)
                    begin
                        radix_next = RADIX_BIN;
                        phase_next = PH_POST;
                    end
                    else if (item.is_blank)
                    begin
                        phase_next = PH_POST;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
                PH_POST:
                begin
                    if (!item.is_blank)
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    phase_next = PH_DIGITS;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            // a digit is taken wherever the character moves into or stays in the digit phase
            if (phase_next == PH_DIGITS)
            begin
                if (!digit_ok)
                begin
                    phase_next = PH_DONE;
                end
                else if (sum_ovf)
                begin
                    acc_next   = '0;
                    ovf_next   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next = sum[ACC_W-1:0];
                end
            end
        end
        mag = {1'b0, acc_next};
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && item.last)
        begin
            number_reg  <= neg_next ? (32'd0 - mag) : mag;
            ovf_out_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            radix_reg     <= RADIX_DEC;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                if (item.last)
                begin
                    phase_reg <= PH_LEAD;
                    acc_reg   <= '0;
                    neg_reg   <= 1'b0;
                    radix_reg <= RADIX_DEC;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    radix_reg <= radix_next;
                    ovf_reg   <= ovf_next;
                end
            end
            if (item_pop && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
